@@ src/ktlb_pkg.sv @@
// Shared types, constants and lookup functions for the knob tone and LED bar block.
package ktlb_pkg;

    // Input request: one tone tick with both knob samples
    typedef struct packed {
        logic [11:0] pitch_sample;
        logic [11:0] level_sample;
    } t_in;

    // Result request: DAC sample, note reload and LED outputs
    typedef struct packed {
        logic [3:0]  dac_value;
        logic [10:0] tone_reload;
        logic [5:0]  led_pattern;
    } t_out;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_SPLIT,
        ST_SCALE,
        ST_COMMIT,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic cfg_write;
        logic capture;
        logic angle;
        logic split;
        logic scale;
        logic commit;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic frame;
    } t_status;

    localparam logic [7:0]  PWM_PERIOD_RESET = 8'd20;
    localparam logic [8:0]  ANGLE_FULL       = 9'd270;
    localparam logic [11:0] ADC_FULL         = 12'd4095;
    localparam int          BAND_STEP        = 34;
    localparam int          BAND_COUNT       = 8;
    localparam logic [8:0]  LIT_FULL_ANGLE   = 9'd265;
    localparam logic [2:0]  LIT_MAX          = 3'd6;
    localparam logic [8:0]  LEVEL_STEP       = 9'd45;
    // floor(a / 45) = (a * 1457) >> 16 for a up to 270
    localparam logic [10:0] DIV45_RECIP      = 11'd1457;
    localparam int          DIV45_SHIFT      = 16;
    // floor(x / 45) = (x * 23302) >> 20 for x up to 44 * 255
    localparam logic [14:0] SCALE_RECIP      = 15'd23302;
    localparam int          SCALE_SHIFT      = 20;

    // One period of a 4-bit sine, 32 points
    localparam logic [3:0] SINE_TAB [32] = '{
        4'd8,  4'd9,  4'd10, 4'd12, 4'd13, 4'd14, 4'd14, 4'd15,
        4'd15, 4'd15, 4'd14, 4'd14, 4'd13, 4'd12, 4'd10, 4'd9,
        4'd8,  4'd6,  4'd5,  4'd3,  4'd2,  4'd1,  4'd1,  4'd0,
        4'd0,  4'd0,  4'd1,  4'd1,  4'd2,  4'd3,  4'd5,  4'd6
    };

    // Map a 12-bit knob reading to 0..270: s * 270 / 4095, with the
    // divide by 4095 done as a shift by 12 plus one correction step
    function automatic logic [8:0] knob_angle(input logic [11:0] s);
        logic [20:0] p;
        logic [8:0]  q0;
        logic [12:0] r;
        p  = 21'(s) * 21'(ANGLE_FULL);
        q0 = p[20:12];
        r  = 13'(p[11:0]) + 13'(q0);
        return (r >= 13'(ADC_FULL)) ? q0 + 9'd1 : q0;
    endfunction

    // Count the 34-degree band edges that the angle lies above
    function automatic logic [2:0] note_band(input logic [8:0] a);
        logic [2:0] b;
        b = 3'd0;
        for (int i = 1; i < BAND_COUNT; i++) begin
            if (a > 9'(BAND_STEP * i)) begin
                b = b + 3'd1;
            end
        end
        return b;
    endfunction

    // Note periods 1908, 1700, 1515, 1432, 1275, 1136, 1012, 956, minus one
    function automatic logic [10:0] note_reload(input logic [2:0] b);
        logic [10:0] v;
        case (b)
            3'd0:    v = 11'd1907;
            3'd1:    v = 11'd1699;
            3'd2:    v = 11'd1514;
            3'd3:    v = 11'd1431;
            3'd4:    v = 11'd1274;
            3'd5:    v = 11'd1135;
            3'd6:    v = 11'd1011;
            default: v = 11'd955;
        endcase
        return v;
    endfunction

endpackage

@@ src/ktlb_ctrl.sv @@
// Controller state machine: sequences one tick request through the datapath.
module ktlb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  logic              i_cfg_valid,
    input  ktlb_pkg::t_status i_status,
    output ktlb_pkg::t_cmd    o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);

    ktlb_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    // Output register can take a new result
    assign out_free = !r_out_valid || !i_out_stall;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ktlb_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ktlb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ktlb_pkg::ST_ANGLE;
                end
            end
            ktlb_pkg::ST_ANGLE: begin
                n_state = i_status.frame ? ktlb_pkg::ST_SPLIT : ktlb_pkg::ST_DONE;
            end
            ktlb_pkg::ST_SPLIT:  n_state = ktlb_pkg::ST_SCALE;
            ktlb_pkg::ST_SCALE:  n_state = ktlb_pkg::ST_COMMIT;
            ktlb_pkg::ST_COMMIT: n_state = ktlb_pkg::ST_DONE;
            ktlb_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ktlb_pkg::ST_IDLE;
                end
            end
            default: n_state = ktlb_pkg::ST_IDLE;
        endcase
    end

    // Commands and handshake outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.cfg_write = i_cfg_valid;
        o_in_stall      = 1'b1;
        case (r_state)
            ktlb_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ktlb_pkg::ST_ANGLE:  o_cmd.angle  = 1'b1;
            ktlb_pkg::ST_SPLIT:  o_cmd.split  = 1'b1;
            ktlb_pkg::ST_SCALE:  o_cmd.scale  = 1'b1;
            ktlb_pkg::ST_COMMIT: o_cmd.commit = 1'b1;
            ktlb_pkg::ST_DONE:   o_cmd.finish = out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    // Hold the result until taken, refill on finish
    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ src/ktlb_dp.sv @@
// Datapath: tick state, knob arithmetic, LED update and result register.
module ktlb_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ktlb_pkg::t_cmd    i_cmd,
    input  logic [7:0]        i_cfg_data,
    input  ktlb_pkg::t_in     i_in_data,
    output ktlb_pkg::t_status o_status,
    output ktlb_pkg::t_out    o_out_data
);

    // Block state
    logic [7:0] r_pwm;
    logic [4:0] r_sine;
    logic [7:0] r_tick;
    logic [2:0] r_lit;
    logic [7:0] r_high;
    logic [5:0] r_led, n_led;

    // Working registers
    logic [11:0]    r_pitch;
    logic [11:0]    r_level;
    logic [2:0]     r_band;
    logic [8:0]     r_lvl_angle;
    logic [2:0]     r_lit_new;
    logic [5:0]     r_rem;
    logic [13:0]    r_prod;
    ktlb_pkg::t_out r_out;

    logic [19:0] div_prod;
    logic [3:0]  div_q;
    logic [28:0] scale_prod;
    logic [2:0]  lit_sat;
    logic [5:0]  fill_mask;
    logic [5:0]  top_mask;

    // Frame tick when the counter meets the period
    assign o_status.frame = (r_tick == r_pwm);

    // Level angle split into whole steps and remainder
    assign div_prod = 20'(r_lvl_angle) * 20'(ktlb_pkg::DIV45_RECIP);
    assign div_q    = div_prod[ktlb_pkg::DIV45_SHIFT +: 4];

    // Remainder scaled to the period, divided by 45
    assign scale_prod = 29'(r_prod) * 29'(ktlb_pkg::SCALE_RECIP);

    // LED update from the lit count and PWM phase
    assign lit_sat   = (r_lit > ktlb_pkg::LIT_MAX) ? ktlb_pkg::LIT_MAX : r_lit;
    assign fill_mask = 6'((7'd1 << lit_sat) - 7'd1);
    assign top_mask  = (lit_sat == 3'd0) ? 6'd0 : 6'(7'd1 << (lit_sat - 3'd1));

    always_comb begin
        if (r_high > r_tick) begin
            n_led = r_led | fill_mask;
        end else begin
            n_led = r_led & ~top_mask;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm  <= ktlb_pkg::PWM_PERIOD_RESET;
            r_sine <= 5'd0;
            r_tick <= 8'd0;
            r_lit  <= 3'd0;
            r_high <= 8'd0;
            r_led  <= 6'd0;
        end else begin
            if (i_cmd.cfg_write) begin
                r_pwm <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_sine <= r_sine + 5'd1;
                r_tick <= r_tick + 8'd1;
            end
            if (i_cmd.commit) begin
                r_lit  <= r_lit_new;
                r_high <= scale_prod[ktlb_pkg::SCALE_SHIFT +: 8];
                r_tick <= 8'd0;
            end
            if (i_cmd.finish) begin
                r_led <= n_led;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pitch <= i_in_data.pitch_sample;
            r_level <= i_in_data.level_sample;
        end
        if (i_cmd.angle) begin
            r_band      <= ktlb_pkg::note_band(ktlb_pkg::knob_angle(r_pitch));
            r_lvl_angle <= ktlb_pkg::knob_angle(r_level);
        end
        if (i_cmd.split) begin
            r_lit_new <= (r_lvl_angle > ktlb_pkg::LIT_FULL_ANGLE) ?
                         ktlb_pkg::LIT_MAX : div_q[2:0];
            r_rem     <= 6'(r_lvl_angle - 9'(9'(div_q) * ktlb_pkg::LEVEL_STEP));
        end
        if (i_cmd.scale) begin
            r_prod <= 14'(r_rem) * 14'(r_pwm);
        end
        if (i_cmd.finish) begin
            r_out.dac_value   <= ktlb_pkg::SINE_TAB[r_sine];
            r_out.tone_reload <= ktlb_pkg::note_reload(r_band);
            r_out.led_pattern <= n_led;
        end
    end

    assign o_out_data = r_out;

endmodule

@@ src/knob_tone_and_led_bar.sv @@
// Top level of the knob tone generator with LED level bar.
// A result is registered in DONE after ANGLE; frame ticks add SPLIT, SCALE, COMMIT.
// Ticks are taken one at a time, in IDLE; a frame tick (every pwm_period ticks)
// takes more controller steps through the shared angle and scaling datapath.
// A held result does not block the next tick until the following result is ready.
// Reset (synchronous, active low) clears block state, LEDs off, pwm_period to 20.
module knob_tone_and_led_bar (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ktlb_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ktlb_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [7:0]     i_cfg_data
);

    ktlb_pkg::t_cmd    cmd;
    ktlb_pkg::t_status status;

    // Accept configuration writes at any time
    assign o_cfg_ready = 1'b1;

    ktlb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    ktlb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

    // Only one request in flight: stall right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a tick was in work");

    // A new result appears only from a tick in work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a tick in work");

    // Reload stays within the note table
    a_reload_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.tone_reload >= 11'd955 &&
                         o_out_data.tone_reload <= 11'd1907))
        else $error("tone reload out of range");

endmodule
